[design/rau_pkg.sv]
// rau_pkg: shared types and constants for the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_SIMP = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD_START, ST_GCD_WAIT, ST_L_START, ST_L_WAIT,
    ST_TA_START, ST_TA_WAIT, ST_TB_START, ST_TB_WAIT,
    ST_SN_START, ST_SN_WAIT, ST_SD_START, ST_SD_WAIT, ST_MUL, ST_DONE
  } state_t;
endpackage
`default_nettype wire

[design/rau_div.sv]
// rau_div: iterative truncating signed divider, one quotient bit per cycle.
// Depends on nothing; used by rational_arithmetic_unit.
`default_nettype none
module rau_div #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] dividend,
  input  wire logic [WORD_BITS-1:0] divisor,
  output logic                      busy,
  output logic [WORD_BITS-1:0]      quot,
  output logic [WORD_BITS-1:0]      rem
);
  localparam int CW = $clog2(WORD_BITS + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [WORD_BITS-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [WORD_BITS:0] trial;
  logic [WORD_BITS-1:0] ma, mb;

  always_comb begin
    ma = dividend[WORD_BITS-1] ? -dividend : dividend;
    mb = divisor[WORD_BITS-1] ? -divisor : divisor;
    trial = {r_r, q_r[WORD_BITS-1]} - {1'b0, d_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = CW'(WORD_BITS);
      q_nxt = ma;
      r_nxt = '0;
      d_nxt = mb;
      qneg_nxt = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      rneg_nxt = dividend[WORD_BITS-1];
    end else if (busy_r) begin
      if (!trial[WORD_BITS]) begin
        r_nxt = trial[WORD_BITS-1:0];
        q_nxt = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WORD_BITS-2:0], q_r[WORD_BITS-1]};
        q_nxt = {q_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign busy = busy_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem = rneg_r ? -r_r : r_r;
endmodule
`default_nettype wire

[design/rational_arithmetic_unit.sv]
// rational_arithmetic_unit: top level, sequencer around one shared divider.
// Depends on rau_pkg and rau_div.
//
//   channel | direction | ports
//   in      | request   | in_valid, in_ready, in_func, in_a_num..in_b_den
//   out     | result    | out_valid, out_ready, out_res_num, out_res_den, ...
//
// An add or subtract request runs one GCD (Euclid steps on the shared divider)
// plus three further divides; a simplify runs one GCD plus two further divides.
// Multiply and divide use no divider and pass through ST_MUL to ST_DONE;
// invalid operands and unused codes go straight to ST_DONE.
// in_ready is high only in idle; the result waits in out registers for out_ready.
// Reset is synchronous and returns to idle with no result pending.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_func,
  input  wire logic [WORD_BITS-1:0] in_a_num,
  input  wire logic [WORD_BITS-1:0] in_a_den,
  input  wire logic [WORD_BITS-1:0] in_b_num,
  input  wire logic [WORD_BITS-1:0] in_b_den,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_BITS-1:0]      out_res_num,
  output logic [WORD_BITS-1:0]      out_res_den,
  output logic                      out_res_valid,
  output logic                      out_ok
);
  import rau_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] fn_r, fn_nxt;
  logic [WORD_BITS-1:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [WORD_BITS-1:0] ga_r, ga_nxt, gb_r, gb_nxt, l_r, l_nxt, ta_r, ta_nxt;
  logic [WORD_BITS-1:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic ok_r, ok_nxt, ov_r, ov_nxt;
  logic dv_start, dv_busy;
  logic [WORD_BITS-1:0] dv_a, dv_b, dv_q, dv_rem, prod;

  rau_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quot(dv_q), .rem(dv_rem)
  );

  always_comb begin
    state_nxt = state_r;
    fn_nxt = fn_r; an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    ga_nxt = ga_r; gb_nxt = gb_r; l_nxt = l_r; ta_nxt = ta_r;
    rn_nxt = rn_r; rd_nxt = rd_r; ok_nxt = ok_r; ov_nxt = ov_r;
    dv_start = 1'b0; dv_a = ga_r; dv_b = gb_r;
    prod = ad_r * bd_r;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fn_nxt = in_func; an_nxt = in_a_num; ad_nxt = in_a_den;
          bn_nxt = in_b_num; bd_nxt = in_b_den;
          rn_nxt = in_a_num; rd_nxt = in_a_den; ok_nxt = 1'b0;
          if (in_func == FN_SIMP) begin
            ga_nxt = in_a_num; gb_nxt = in_a_den;
            state_nxt = (in_a_den == '0) ? ST_DONE : ST_GCD_START;
          end else if (in_func > FN_SIMP) begin
            state_nxt = ST_DONE;
          end else if (in_a_den == '0) begin
            rn_nxt = in_b_num; rd_nxt = in_b_den; state_nxt = ST_DONE;
          end else if (in_b_den == '0) begin
            state_nxt = ST_DONE;
          end else if (in_func == FN_MUL || in_func == FN_DIV) begin
            state_nxt = ST_MUL;
          end else begin
            ga_nxt = in_a_den; gb_nxt = in_b_den; state_nxt = ST_GCD_START;
          end
        end
      end
      ST_GCD_START: begin
        if (gb_r == '0) begin
          state_nxt = (fn_r == FN_SIMP) ? ST_SN_START : ST_L_START;
        end else begin
          dv_start = 1'b1; state_nxt = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: if (!dv_busy) begin
        ga_nxt = gb_r; gb_nxt = dv_rem; state_nxt = ST_GCD_START;
      end
      ST_L_START: begin
        dv_a = prod; dv_b = ga_r; dv_start = 1'b1; state_nxt = ST_L_WAIT;
      end
      ST_L_WAIT: if (!dv_busy) begin
        l_nxt = dv_q; state_nxt = ST_TA_START;
      end
      ST_TA_START: begin
        dv_a = l_r; dv_b = ad_r; dv_start = 1'b1; state_nxt = ST_TA_WAIT;
      end
      ST_TA_WAIT: if (!dv_busy) begin
        ta_nxt = dv_q * an_r; state_nxt = ST_TB_START;
      end
      ST_TB_START: begin
        dv_a = l_r; dv_b = bd_r; dv_start = 1'b1; state_nxt = ST_TB_WAIT;
      end
      ST_TB_WAIT: if (!dv_busy) begin
        rn_nxt = (fn_r == FN_ADD) ? ta_r + dv_q * bn_r : ta_r - dv_q * bn_r;
        rd_nxt = l_r; ok_nxt = 1'b1; state_nxt = ST_DONE;
      end
      ST_SN_START: begin
        dv_a = an_r; dv_b = ga_r; dv_start = 1'b1; state_nxt = ST_SN_WAIT;
      end
      ST_SN_WAIT: if (!dv_busy) begin
        rn_nxt = dv_q; state_nxt = ST_SD_START;
      end
      ST_SD_START: begin
        dv_a = ad_r; dv_b = ga_r; dv_start = 1'b1; state_nxt = ST_SD_WAIT;
      end
      ST_SD_WAIT: if (!dv_busy) begin
        rn_nxt = dv_q[WORD_BITS-1] ? -rn_r : rn_r;
        rd_nxt = dv_q[WORD_BITS-1] ? -dv_q : dv_q;
        ok_nxt = 1'b1; state_nxt = ST_DONE;
      end
      ST_MUL: begin
        rn_nxt = (fn_r == FN_MUL) ? an_r * bn_r : an_r * bd_r;
        rd_nxt = (fn_r == FN_MUL) ? ad_r * bd_r : ad_r * bn_r;
        ok_nxt = 1'b1; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (state_r == ST_IDLE) in_ready = !ov_r || out_ready;
    if (state_r == ST_IDLE && !(!ov_r || out_ready)) begin
      state_nxt = ST_IDLE; fn_nxt = fn_r; an_nxt = an_r; ad_nxt = ad_r;
      bn_nxt = bn_r; bd_nxt = bd_r; ga_nxt = ga_r; gb_nxt = gb_r;
      rn_nxt = rn_r; rd_nxt = rd_r; ok_nxt = ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
    fn_r <= fn_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; l_r <= l_nxt; ta_r <= ta_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; ok_r <= ok_nxt;
  end

  assign out_valid = ov_r;
  assign out_res_num = rn_r;
  assign out_res_den = rd_r;
  assign out_res_valid = (rd_r != '0);
  assign out_ok = ok_r;
endmodule
`default_nettype wire
